>>> sv/spi_rp_pkg.sv
// ----------------------------------------------------------------------------
// spi reply parser package
// shared codes and the result record of the co-processor reply frame parser
// ----------------------------------------------------------------------------
package spi_rp_pkg;

   // request operations
   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_DATA = 3'd1,
      KIND_LEN  = 3'd2,
      KIND_DONE = 3'd3,
      KIND_ERR  = 3'd4
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_MARKER  = 3'd1,
      ERR_TIMEOUT = 3'd2,
      ERR_REPLY   = 3'd3,
      ERR_TOOLONG = 3'd4,
      ERR_BADEND  = 3'd5
   } err_type;

   // frame markers
   localparam logic [7:0] MARK_START = 8'hE0;
   localparam logic [7:0] MARK_END   = 8'hEE;
   localparam logic [7:0] MARK_ERROR = 8'hEF;

   // register map
   localparam int          CSR_ADDR_W      = 3;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  value_index;
      logic [15:0] value_length;
      logic        last_of_value;
      err_type     error_code;
   } result_type;

endpackage

>>> sv/spi_rp_req_if.sv
// ----------------------------------------------------------------------------
// spi reply parser request channel
// valid/ready channel carrying one parser request
// ----------------------------------------------------------------------------
interface spi_rp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  rx_byte;
   logic [6:0]  expect_cmd;
   logic [7:0]  want_values;
   logic        wide_length;
   logic [15:0] capacity;

   modport source (
      output valid, opcode, rx_byte, expect_cmd, want_values, wide_length, capacity,
      input  ready
   );
   modport sink (
      input  valid, opcode, rx_byte, expect_cmd, want_values, wide_length, capacity,
      output ready
   );
endinterface

>>> sv/spi_rp_rsp_if.sv
// ----------------------------------------------------------------------------
// spi reply parser result channel
// valid/ready channel carrying one parser result
// ----------------------------------------------------------------------------
interface spi_rp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  value_index;
   logic [15:0] value_length;
   logic        last_of_value;
   logic [2:0]  error_code;

   modport source (
      output valid, kind, data_byte, value_index, value_length, last_of_value,
             error_code,
      input  ready
   );
   modport sink (
      input  valid, kind, data_byte, value_index, value_length, last_of_value,
             error_code,
      output ready
   );
endinterface

>>> sv/spi_response_parser.sv
// ----------------------------------------------------------------------------
// spi response parser
// parses a co-processor reply frame one received byte per request
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          opcode, rx_byte, begin fields
//   rsp_chan  out        valid/ready          kind, byte, index, length, error
//   csr (apb) in         psel/penable/pready  timeout_ticks at address 0
//
// one request is taken per cycle; its result is registered into the output or
// skid register. the parser state update is a single pass of compares and
// small adders. a two-entry output buffer (output register plus skid register)
// lets requests keep flowing for one stalled result; req ready drops only
// while the skid register is full. reset is synchronous and returns the
// parser to idle with timeout_ticks at 1000.
//
module spi_response_parser
   import spi_rp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   spi_rp_req_if.sink            req_chan,
   spi_rp_rsp_if.source          rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_WAIT  = 3'd1,
      PH_CMD   = 3'd2,
      PH_COUNT = 3'd3,
      PH_LEN1  = 3'd4,
      PH_LEN2  = 3'd5,
      PH_DATA  = 3'd6,
      PH_END   = 3'd7
   } phase_type;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [6:0]  expected_code_ff, expected_code_in;
   logic [7:0]  values_left_ff, values_left_in;
   logic        length_is_wide_ff, length_is_wide_in;
   logic [15:0] capacity_held_ff, capacity_held_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  current_index_ff, current_index_in;
   logic [15:0] wait_ticks_ff, wait_ticks_in;
   logic [15:0] timeout_ticks_ff;

   // output buffer
   result_type  out_ff, skid_ff, result;
   logic        out_valid_ff, skid_valid_ff;

   logic        req_take;
   logic        rsp_pop;
   logic        csr_write;
   op_type      op;
   logic [7:0]  rx;
   logic [15:0] len_sel;
   logic [15:0] ticks_inc;
   logic [7:0]  values_dec;
   logic [7:0]  count_clip;

   assign op        = op_type'(req_chan.opcode);
   assign rx        = req_chan.rx_byte;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign rsp_pop   = out_valid_ff && rsp_chan.ready;
   assign csr_write = psel && penable && pwrite;

   // ready only depends on the skid slot
   assign req_chan.ready = !skid_valid_ff;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {16'h0000, timeout_ticks_ff} : 32'h0000_0000;

   // length as seen by the length check: one byte, or high byte held plus low byte
   assign len_sel    = (phase_ff == PH_LEN2) ? {bytes_left_ff[15:8], rx} : {8'h00, rx};
   // saturating tick count
   assign ticks_inc  = (wait_ticks_ff == 16'hFFFF) ? wait_ticks_ff : wait_ticks_ff + 16'd1;
   assign values_dec = values_left_ff - 8'd1;
   assign count_clip = (rx < values_left_ff) ? rx : values_left_ff;

   // next parser state and result of the request at the port
   always_comb begin
      phase_in          = phase_ff;
      expected_code_in  = expected_code_ff;
      values_left_in    = values_left_ff;
      length_is_wide_in = length_is_wide_ff;
      capacity_held_in  = capacity_held_ff;
      bytes_left_in     = bytes_left_ff;
      current_index_in  = current_index_ff;
      wait_ticks_in     = wait_ticks_ff;
      result            = '{KIND_NONE, 8'h00, 8'h00, 16'h0000, 1'b0, ERR_NONE};

      unique case (op)
         OP_BEGIN: begin
            // a begin always restarts, dropping any frame in progress
            expected_code_in  = req_chan.expect_cmd;
            values_left_in    = req_chan.want_values;
            length_is_wide_in = req_chan.wide_length;
            capacity_held_in  = req_chan.capacity;
            bytes_left_in     = 16'h0000;
            current_index_in  = 8'h00;
            wait_ticks_in     = 16'h0000;
            phase_in          = PH_WAIT;
         end
         OP_TICK: begin
            if (phase_ff == PH_WAIT) begin
               wait_ticks_in = ticks_inc;
               if (ticks_inc >= timeout_ticks_ff) begin
                  phase_in          = PH_IDLE;
                  result.kind       = KIND_ERR;
                  result.error_code = ERR_TIMEOUT;
               end
            end
         end
         OP_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  // stray byte, nothing to do
               end
               PH_WAIT: begin
                  priority if (rx == MARK_START) begin
                     phase_in = PH_CMD;
                  end else if (rx == MARK_ERROR) begin
                     phase_in          = PH_IDLE;
                     result.kind       = KIND_ERR;
                     result.error_code = ERR_MARKER;
                  end else if (wait_ticks_ff >= timeout_ticks_ff) begin
                     phase_in          = PH_IDLE;
                     result.kind       = KIND_ERR;
                     result.error_code = ERR_TIMEOUT;
                  end else begin
                     // other byte, keep waiting
                  end
               end
               PH_CMD: begin
                  if (rx == {1'b1, expected_code_ff}) begin
                     phase_in = PH_COUNT;
                  end else begin
                     phase_in          = PH_IDLE;
                     result.kind       = KIND_ERR;
                     result.error_code = ERR_REPLY;
                  end
               end
               PH_COUNT: begin
                  values_left_in = count_clip;
                  phase_in       = (count_clip == 8'h00) ? PH_END : PH_LEN1;
               end
               PH_LEN1, PH_LEN2: begin
                  if (phase_ff == PH_LEN1 && length_is_wide_ff) begin
                     // hold the high byte until the low byte arrives
                     bytes_left_in = {rx, 8'h00};
                     phase_in      = PH_LEN2;
                  end else if (len_sel > capacity_held_ff) begin
                     phase_in          = PH_IDLE;
                     result.kind       = KIND_ERR;
                     result.error_code = ERR_TOOLONG;
                  end else begin
                     result.kind         = KIND_LEN;
                     result.value_index  = current_index_ff;
                     result.value_length = len_sel;
                     bytes_left_in       = len_sel;
                     if (len_sel == 16'h0000) begin
                        // empty value closes at once
                        current_index_in = current_index_ff + 8'd1;
                        values_left_in   = values_dec;
                        phase_in         = (values_dec == 8'h00) ? PH_END : PH_LEN1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  result.kind          = KIND_DATA;
                  result.data_byte     = rx;
                  result.value_index   = current_index_ff;
                  result.last_of_value = (bytes_left_ff == 16'd1);
                  bytes_left_in        = bytes_left_ff - 16'd1;
                  if (bytes_left_ff == 16'd1) begin
                     current_index_in = current_index_ff + 8'd1;
                     values_left_in   = values_dec;
                     phase_in         = (values_dec == 8'h00) ? PH_END : PH_LEN1;
                  end
               end
               PH_END: begin
                  phase_in = PH_IDLE;
                  if (rx == MARK_END) begin
                     result.kind = KIND_DONE;
                  end else begin
                     result.kind       = KIND_ERR;
                     result.error_code = ERR_BADEND;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            // unused opcode leaves the parser state alone
         end
      endcase
   end

   // parser state, timeout register, output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         expected_code_ff  <= 7'h00;
         values_left_ff    <= 8'h00;
         length_is_wide_ff <= 1'b0;
         capacity_held_ff  <= 16'h0000;
         bytes_left_ff     <= 16'h0000;
         current_index_ff  <= 8'h00;
         wait_ticks_ff     <= 16'h0000;
         timeout_ticks_ff  <= TIMEOUT_RESET;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff          <= phase_in;
            expected_code_ff  <= expected_code_in;
            values_left_ff    <= values_left_in;
            length_is_wide_ff <= length_is_wide_in;
            capacity_held_ff  <= capacity_held_in;
            bytes_left_ff     <= bytes_left_in;
            current_index_ff  <= current_index_in;
            wait_ticks_ff     <= wait_ticks_in;
         end
         if (csr_write && paddr[2] == 1'b0) begin
            timeout_ticks_ff <= pwdata[15:0];
         end
         priority if (skid_valid_ff) begin
            // no new request while the skid slot is full
            if (rsp_pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take && (!out_valid_ff || rsp_pop)) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else if (req_take) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end else begin
            // nothing moves on the result side
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.data_byte     = out_ff.data_byte;
   assign rsp_chan.value_index   = out_ff.value_index;
   assign rsp_chan.value_length  = out_ff.value_length;
   assign rsp_chan.last_of_value = out_ff.last_of_value;
   assign rsp_chan.error_code    = out_ff.error_code;

   // skid slot only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full with empty output register");

   // a begin always arms the wait
   a_begin_arms: assert property (@(posedge clock) disable iff (reset)
      (req_take && op == OP_BEGIN) |=> phase_ff == PH_WAIT)
      else $error("begin did not arm the wait");

   // an error result always carries a code, others never do
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.kind == KIND_ERR) == (out_ff.error_code != ERR_NONE)))
      else $error("error kind and error code disagree");

   // a stalled request holds the parser state
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(phase_ff) && $stable(bytes_left_ff))
      else $error("parser state moved without a request");

endmodule

>>> dv/spi_response_parser_tb.sv
// ----------------------------------------------------------------------------
// spi response parser testbench
// drives reply frames, ticks and begin requests into the parser while a
// built-in model of the frame parser predicts every result. results are
// compared field by field in order. the timeout register is rewritten
// between phases of different sender and receiver idling, and one phase
// stalls the receiver long enough to back up the request channel.
// ----------------------------------------------------------------------------
module spi_response_parser_tb;
   import spi_rp_pkg::*;

   localparam int                    CYCLE_LIMIT  = 300000;
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = '0;

   // parser position within a reply frame
   typedef enum logic [2:0] {
      PS_IDLE,
      PS_WAIT,
      PS_CMD,
      PS_COUNT,
      PS_LEN_HI,
      PS_LEN_LO,
      PS_DATA,
      PS_END
   } parse_phase_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  rx_byte;
      logic [6:0]  expect_cmd;
      logic [7:0]  want_values;
      logic        wide_length;
      logic [15:0] capacity;
   } parser_req_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   spi_rp_req_if req_chan();
   spi_rp_rsp_if rsp_chan();

   spi_response_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame parser model state, kept in step with accepted requests
   parse_phase_type parse_phase;
   logic [6:0]   cmd_expected;
   logic [7:0]   values_remaining;
   logic         wide_len;
   logic [15:0]  cap_limit;
   logic [15:0]  bytes_remaining;
   logic [7:0]   value_idx;
   logic [15:0]  ticks_waited;
   logic [15:0]  timeout_limit;

   // results still owed by the parser, oldest first
   result_type expected_results[$];

   int reqs_sent;
   int results_checked;
   int mismatches;
   int cycle_count;
   int kind_seen[8];
   int error_seen[8];

   // idling knobs, in percent of cycles
   int send_gap_pct;
   int recv_stall_pct;
   // long receiver hold-off asked by a test, in cycles
   int hold_request;

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------

   function automatic result_type parse_error(input err_type code);
      result_type res;
      res = '0;
      parse_phase = PS_IDLE;
      res.kind = KIND_ERR;
      res.error_code = code;
      return res;
   endfunction

   // one value fully delivered: move to the next length or to the end marker
   function automatic void finish_value();
      value_idx = value_idx + 8'd1;
      values_remaining = values_remaining - 8'd1;
      parse_phase = (values_remaining == 8'd0) ? PS_END : PS_LEN_HI;
   endfunction

   function automatic result_type accept_length(input logic [15:0] len);
      result_type res;
      res = '0;
      if (len > cap_limit) return parse_error(ERR_TOOLONG);
      res.kind = KIND_LEN;
      res.value_index = value_idx;
      res.value_length = len;
      bytes_remaining = len;
      if (len == 16'd0) finish_value();
      else parse_phase = PS_DATA;
      return res;
   endfunction

   function automatic result_type predict_result(input parser_req_type r);
      result_type res;
      logic [7:0] n;
      res = '0;
      case (r.opcode)
         OP_BEGIN: begin
            // also drops any frame in progress
            cmd_expected = r.expect_cmd;
            values_remaining = r.want_values;
            wide_len = r.wide_length;
            cap_limit = r.capacity;
            bytes_remaining = '0;
            value_idx = '0;
            ticks_waited = '0;
            parse_phase = PS_WAIT;
         end
         OP_TICK: begin
            if (parse_phase == PS_WAIT) begin
               if (ticks_waited != 16'hFFFF) ticks_waited = ticks_waited + 16'd1;
               if (ticks_waited >= timeout_limit) res = parse_error(ERR_TIMEOUT);
            end
         end
         OP_BYTE: begin
            case (parse_phase)
               PS_WAIT: begin
                  if (r.rx_byte == MARK_START) parse_phase = PS_CMD;
                  else if (r.rx_byte == MARK_ERROR) res = parse_error(ERR_MARKER);
                  else if (ticks_waited >= timeout_limit) res = parse_error(ERR_TIMEOUT);
               end
               PS_CMD: begin
                  if (r.rx_byte == {1'b1, cmd_expected}) parse_phase = PS_COUNT;
                  else res = parse_error(ERR_REPLY);
               end
               PS_COUNT: begin
                  n = (r.rx_byte < values_remaining) ? r.rx_byte : values_remaining;
                  values_remaining = n;
                  parse_phase = (n == 8'd0) ? PS_END : PS_LEN_HI;
               end
               PS_LEN_HI: begin
                  if (wide_len) begin
                     bytes_remaining = {r.rx_byte, 8'h00};
                     parse_phase = PS_LEN_LO;
                  end else begin
                     res = accept_length({8'h00, r.rx_byte});
                  end
               end
               PS_LEN_LO: res = accept_length({bytes_remaining[15:8], r.rx_byte});
               PS_DATA: begin
                  res.kind = KIND_DATA;
                  res.data_byte = r.rx_byte;
                  res.value_index = value_idx;
                  res.last_of_value = (bytes_remaining == 16'd1);
                  bytes_remaining = bytes_remaining - 16'd1;
                  if (bytes_remaining == 16'd0) finish_value();
               end
               PS_END: begin
                  if (r.rx_byte == MARK_END) begin
                     parse_phase = PS_IDLE;
                     res.kind = KIND_DONE;
                  end else begin
                     res = parse_error(ERR_BADEND);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endfunction

   function automatic string show_result(input result_type r);
      return $sformatf("kind %0d byte %02h index %0d length %0d last %b error %0d",
                       r.kind, r.data_byte, r.value_index, r.value_length,
                       r.last_of_value, r.error_code);
   endfunction

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin
      result_type seen;
      result_type due;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen.kind = kind_type'(rsp_chan.kind);
         seen.data_byte = rsp_chan.data_byte;
         seen.value_index = rsp_chan.value_index;
         seen.value_length = rsp_chan.value_length;
         seen.last_of_value = rsp_chan.last_of_value;
         seen.error_code = err_type'(rsp_chan.error_code);
         results_checked++;
         kind_seen[rsp_chan.kind]++;
         error_seen[rsp_chan.error_code]++;
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending: %s", show_result(seen)));
         end else begin
            due = expected_results.pop_front();
            if (seen.kind !== due.kind || seen.data_byte !== due.data_byte ||
                seen.value_index !== due.value_index ||
                seen.value_length !== due.value_length ||
                seen.last_of_value !== due.last_of_value ||
                seen.error_code !== due.error_code)
               note_mismatch($sformatf("expected %s, got %s", show_result(due),
                                       show_result(seen)));
         end
      end
   end

   // receiver: random stalls, or a long hold-off when a test asks for one
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped: limit of %0d cycles reached", CYCLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // request driving
   // ------------------------------------------------------------------------

   function automatic parser_req_type random_req();
      parser_req_type r;
      r.opcode = op_type'($urandom_range(0, 3));
      r.rx_byte = 8'($urandom);
      r.expect_cmd = 7'($urandom);
      r.want_values = 8'($urandom);
      r.wide_length = 1'($urandom);
      r.capacity = 16'($urandom);
      return r;
   endfunction

   // offer one request, possibly after idle cycles, and predict its result
   // once the parser takes it; entered and left at a rising edge
   task automatic send_req(input parser_req_type r);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= r.opcode;
      req_chan.rx_byte <= r.rx_byte;
      req_chan.expect_cmd <= r.expect_cmd;
      req_chan.want_values <= r.want_values;
      req_chan.wide_length <= r.wide_length;
      req_chan.capacity <= r.capacity;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_results.push_back(predict_result(r));
      reqs_sent++;
   endtask

   // unused request fields carry random values
   task automatic send_byte(input logic [7:0] b);
      parser_req_type r;
      r = random_req();
      r.opcode = OP_BYTE;
      r.rx_byte = b;
      send_req(r);
   endtask

   task automatic send_tick();
      parser_req_type r;
      r = random_req();
      r.opcode = OP_TICK;
      send_req(r);
   endtask

   task automatic send_begin(input logic [6:0] cmd, input logic [7:0] want,
                             input logic wide, input logic [15:0] cap);
      parser_req_type r;
      r = random_req();
      r.opcode = OP_BEGIN;
      r.expect_cmd = cmd;
      r.want_values = want;
      r.wide_length = wide;
      r.capacity = cap;
      send_req(r);
   endtask

   // stop offering requests until every predicted result has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // write the timeout register, then read it back
   task automatic write_timeout(input logic [15:0] ticks);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= TIMEOUT_ADDR;
      pwdata <= {16'($urandom), ticks};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      timeout_limit = ticks;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[15:0] !== timeout_limit)
         note_mismatch($sformatf("timeout readback %0d, expected %0d", prdata[15:0],
                                 timeout_limit));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // a corrupted frame gets an occasional byte replaced
   task automatic frame_byte(input logic [7:0] b, input bit corrupt);
      if (corrupt && $urandom_range(0, 14) == 0) b = 8'($urandom);
      send_byte(b);
   endtask

   // one reply frame with random content: begin, some noise and ticks, start
   // marker, reply code, count, values and end marker
   task automatic send_random_frame();
      logic [6:0]  cmd;
      logic [7:0]  want;
      logic [7:0]  count;
      logic [7:0]  n_vals;
      logic [7:0]  b;
      logic        wide;
      logic [15:0] cap;
      logic [15:0] len;
      bit          corrupt;
      cmd = 7'($urandom);
      wide = 1'($urandom);
      // keep the number of values small: only one of want and count is large
      case ($urandom_range(0, 9))
         0: begin
            want = 8'($urandom);
            count = 8'($urandom_range(0, 3));
         end
         1: begin
            want = 8'($urandom_range(0, 3));
            count = 8'($urandom);
         end
         default: begin
            want = 8'($urandom_range(0, 3));
            count = 8'($urandom_range(0, 3));
         end
      endcase
      case ($urandom_range(0, 4))
         0: cap = 16'($urandom);
         1: cap = 16'd0;
         default: cap = 16'($urandom_range(1, 8));
      endcase
      corrupt = ($urandom_range(0, 99) < 12);
      send_begin(cmd, want, wide, cap);
      // bytes and ticks before the start marker; markers mostly kept out
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1) == 0) begin
            send_tick();
         end else begin
            b = 8'($urandom);
            if ((b == MARK_START || b == MARK_ERROR) && $urandom_range(0, 9) != 0) b = 8'h00;
            send_byte(b);
         end
      end
      // a frame that never starts
      if ($urandom_range(0, 19) == 0) return;
      frame_byte(MARK_START, corrupt);
      frame_byte({1'b1, cmd}, corrupt);
      frame_byte(count, corrupt);
      n_vals = (count < want) ? count : want;
      for (int i = 0; i < n_vals; i++) begin
         // now and then a length beyond the capacity
         if ($urandom_range(0, 9) == 0 && cap != 16'hFFFF && (wide || cap < 16'd255))
            len = wide ? 16'($urandom_range(cap + 1, 65535))
                       : 16'($urandom_range(cap + 1, 255));
         else
            len = 16'($urandom_range(0, (cap < 16'd6) ? cap : 6));
         if (wide) frame_byte(len[15:8], corrupt);
         frame_byte(len[7:0], corrupt);
         if (len <= cap) repeat (len) frame_byte(8'($urandom), corrupt);
      end
      if ($urandom_range(0, 19) != 0) frame_byte(MARK_END, corrupt);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // bytes and ticks while idle and the spare opcode change nothing
   task automatic test_idle_requests();
      parser_req_type r;
      send_byte(MARK_START);
      send_tick();
      r = random_req();
      r.opcode = OP_SPARE;
      send_req(r);
   endtask

   // short-length frame: count clipped to the wanted number, one data byte
   // marked last, a zero-length value, then the end marker
   task automatic test_narrow_frame();
      send_begin(7'h7F, 8'd2, 1'b0, 16'd1);
      send_byte(MARK_START);
      send_byte(8'hFF);
      send_byte(8'd3);
      send_byte(8'd1);
      send_byte(8'hFF);
      send_byte(8'd0);
      send_byte(MARK_END);
   endtask

   // begin in the middle of a frame restarts; zero values go straight to the
   // end check, which then fails on a wrong byte
   task automatic test_busy_restart();
      send_begin(7'h00, 8'd255, 1'b1, 16'hFFFF);
      send_byte(MARK_START);
      send_begin(7'h01, 8'd0, 1'b0, 16'd0);
      send_byte(MARK_START);
      send_byte(8'h81);
      send_byte(8'd5);
      send_byte(8'hAA);
   endtask

   // with a zero timeout: error marker, timeout on a byte, timeout on a tick,
   // and a wrong reply code after a good start
   task automatic test_zero_timeout();
      wait_for_results();
      write_timeout(16'd0);
      send_begin(7'h11, 8'd1, 1'b0, 16'd4);
      send_byte(MARK_ERROR);
      send_begin(7'h11, 8'd1, 1'b0, 16'd4);
      send_byte(8'h12);
      send_begin(7'h11, 8'd1, 1'b0, 16'd4);
      send_tick();
      send_begin(7'h05, 8'd1, 1'b1, 16'd4);
      send_byte(MARK_START);
      send_byte(8'h80);
   endtask

   // random frames and noise under one timeout and one idling setting
   task automatic test_random_traffic(input logic [15:0] ticks, input int gap_pct,
                                      input int stall_pct, input int n_reqs);
      int stop_at;
      wait_for_results();
      write_timeout(ticks);
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      stop_at = reqs_sent + n_reqs;
      while (reqs_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) send_req(random_req());
         else send_random_frame();
      end
   endtask

   // receiver held off while requests keep coming, so the output buffer fills
   // and request ready drops; then the sender pauses until all has drained
   task automatic test_backpressure();
      int stop_at;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hold_request = 300;
      stop_at = reqs_sent + 60;
      while (reqs_sent < stop_at) send_random_frame();
      wait_for_results();
      stop_at = reqs_sent + 60;
      while (reqs_sent < stop_at) send_random_frame();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_BEGIN;
      req_chan.rx_byte <= '0;
      req_chan.expect_cmd <= '0;
      req_chan.want_values <= '0;
      req_chan.wide_length <= 1'b0;
      req_chan.capacity <= '0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;

      // model state after reset
      parse_phase = PS_IDLE;
      cmd_expected = '0;
      values_remaining = '0;
      wide_len = 1'b0;
      cap_limit = '0;
      bytes_remaining = '0;
      value_idx = '0;
      ticks_waited = '0;
      timeout_limit = TIMEOUT_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_narrow_frame();
      test_busy_restart();
      test_zero_timeout();
      test_random_traffic(16'hFFFF, 0, 0, 250);
      test_backpressure();
      test_random_traffic(16'd2, 47, 0, 250);
      test_random_traffic(16'($urandom_range(1, 5)), 0, 47, 250);
      test_random_traffic(TIMEOUT_RESET, 16, 16, 250);

      // drain, then give a late stray result a chance to show up
      wait_for_results();
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("covered %0d requests, %0d results: data %0d, length %0d, done %0d, none %0d",
               reqs_sent, results_checked, kind_seen[KIND_DATA], kind_seen[KIND_LEN],
               kind_seen[KIND_DONE], kind_seen[KIND_NONE]);
      $display("errors seen: marker %0d, timeout %0d, reply %0d, too long %0d, bad end %0d",
               error_seen[ERR_MARKER], error_seen[ERR_TIMEOUT], error_seen[ERR_REPLY],
               error_seen[ERR_TOOLONG], error_seen[ERR_BADEND]);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/spi_rp_pkg.sv
sv/spi_rp_req_if.sv
sv/spi_rp_rsp_if.sv
sv/spi_response_parser.sv
dv/spi_response_parser_tb.sv
